@@ src/tof_to_mz_sqrt_calibration_top_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the sqrt-linear TOF calibration block
// Both macros sample on clk and are disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef TOF_TO_MZ_SQRT_CALIBRATION_TOP_MACROS_SVH
`define TOF_TO_MZ_SQRT_CALIBRATION_TOP_MACROS_SVH

// Same-cycle implication.
`define TMC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/tmc_pkg.sv @@
// ---------------------------------------------------------------------------
// tmc_pkg
// Shared formats, constants and helper functions of the sqrt-linear
// time-of-flight / m/z calibration pipeline.
// ---------------------------------------------------------------------------
package tmc_pkg;

	// Field formats.
	localparam int MZ_W      = 32;   // m/z, unsigned Q16.16
	localparam int ICPT_W    = 32;   // intercept, signed Q8.24
	localparam int SLOPE_W   = 48;   // slope, unsigned Q0.48
	localparam int CFG_W     = 48;   // widest register
	localparam int CFG_IDX_W = 1;

	// Register map.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INTERCEPT = 1'b0,
		REG_SLOPE     = 1'b1
	} cfg_reg_t;

	// Forward path: slope is split into a 32-bit low part and a 16-bit high part.
	localparam int SLOPE_LO_W  = 32;
	localparam int PROD_SHIFT  = 16;  // slope*tof brought to 32 fraction bits
	localparam int PROD_LIM_B  = 41;  // product at or above 2^41 saturates
	localparam int ICPT_SHIFT  = 8;   // Q8.24 to 32 fraction bits
	localparam int VAL_W       = 43;  // signed sum of intercept and product
	localparam int ABS_W       = 40;  // magnitude at or above 2^40 saturates
	localparam int HALF_W      = 20;  // magnitude is squared in two halves
	localparam int SQ_W        = 81;  // square plus rounding carry
	localparam int RND_BIT     = 47;  // half of the dropped 48 fraction bits
	localparam int MZ_LSB      = 48;
	localparam int FWD_STAGES  = 6;

	// Inverse path: square root, two bits of root per stage.
	localparam int ROOT_W     = 32;
	localparam int REM_W      = 34;
	localparam int SQ_STAGES  = 16;

	// Inverse path: divider front end.
	localparam int DIFF_W     = 33;   // positive difference root - intercept
	localparam int NUM_SHIFT  = 25;
	localparam int NUM_W      = 59;
	localparam int DIV_W      = 49;   // divisor 2*slope
	localparam int DIV_PRE    = 2;

	// Result of the forward path.
	typedef struct packed {
		logic            clip;
		logic [MZ_W-1:0] mz;
	} fwd_res_t;

	// Partial state of the digit-by-digit square root.
	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_state_t;

	// One root bit: bring down the next pair of radicand bits and try a 1.
	function automatic sq_state_t sqrt_step(input sq_state_t cur, input logic [1:0] pair);
		logic [REM_W+1:0] rem_sh;
		logic [REM_W+1:0] trial;
		sq_state_t        nxt;
		rem_sh = {cur.rem, pair};
		trial  = (REM_W+2)'({cur.root, 2'b01});
		if (rem_sh >= trial) begin
			nxt.rem  = REM_W'(rem_sh - trial);
			nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = REM_W'(rem_sh);
			nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

@@ src/tmc_fwd.sv @@
// ---------------------------------------------------------------------------
// tmc_fwd
// Forward conversion pipeline: m/z = (intercept + slope*tof)^2, rounded
// half up to Q16.16 and saturated.
// ---------------------------------------------------------------------------
module tmc_fwd import tmc_pkg::*; #(
	parameter int TOF_WIDTH = 20
) (
	input  logic                     clk,
	input  logic                     adv,
	input  logic [SLOPE_W-1:0]       slope,
	input  logic [ICPT_W-1:0]        icpt,
	input  logic [TOF_WIDTH-1:0]     tof,
	output fwd_res_t                 res
);

	localparam int PLO_W  = SLOPE_LO_W + TOF_WIDTH;
	localparam int PHI_W  = SLOPE_W - SLOPE_LO_W + TOF_WIDTH;
	localparam int PROD_W = PHI_W + PROD_SHIFT;

	logic [PLO_W-1:0]      plo_s1;
	logic [PHI_W-1:0]      phi_s1;
	logic [PROD_LIM_B-1:0] prod_s2;
	logic                  ovf_s2;
	logic [VAL_W-1:0]      val_s3;
	logic                  ovf_s3;
	logic [ABS_W-1:0]      a_s4;
	logic                  ovf_s4;
	logic [ABS_W-1:0]      hh_s5, hl_s5, ll_s5;
	logic                  ovf_s5;
	fwd_res_t              res_s6;

	logic [PROD_W-1:0]     prod;
	logic [VAL_W-1:0]      val;
	logic [VAL_W-1:0]      mag;
	logic [SQ_W-1:0]       sum;

	// Stage 1: partial products of slope and tof.
	always_ff @(posedge clk) begin
		if (adv) begin
			plo_s1 <= PLO_W'(slope[SLOPE_LO_W-1:0]) * PLO_W'(tof);
			phi_s1 <= PHI_W'(slope[SLOPE_W-1:SLOPE_LO_W]) * PHI_W'(tof);
		end
	end

	// Stage 2: product with 32 fraction bits, truncated, and its range check.
	always_comb begin
		prod = {phi_s1, {PROD_SHIFT{1'b0}}} + PROD_W'(plo_s1 >> PROD_SHIFT);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= prod[PROD_LIM_B-1:0];
			ovf_s2  <= |prod[PROD_W-1:PROD_LIM_B];
		end
	end

	// Stage 3: add the intercept.
	always_comb begin
		val = {{(VAL_W-ICPT_W-ICPT_SHIFT){icpt[ICPT_W-1]}}, icpt, {ICPT_SHIFT{1'b0}}}
			+ VAL_W'(prod_s2);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_s3 <= val;
			ovf_s3 <= ovf_s2;
		end
	end

	// Stage 4: magnitude and its range check.
	always_comb begin
		mag = val_s3[VAL_W-1] ? (-val_s3) : val_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s4   <= mag[ABS_W-1:0];
			ovf_s4 <= ovf_s3 | (|mag[VAL_W-1:ABS_W]);
		end
	end

	// Stage 5: square as three half-width products.
	always_ff @(posedge clk) begin
		if (adv) begin
			hh_s5  <= ABS_W'(a_s4[ABS_W-1:HALF_W]) * ABS_W'(a_s4[ABS_W-1:HALF_W]);
			hl_s5  <= ABS_W'(a_s4[ABS_W-1:HALF_W]) * ABS_W'(a_s4[HALF_W-1:0]);
			ll_s5  <= ABS_W'(a_s4[HALF_W-1:0]) * ABS_W'(a_s4[HALF_W-1:0]);
			ovf_s5 <= ovf_s4;
		end
	end

	// Stage 6: sum the partials, round half up and saturate.
	always_comb begin
		sum = SQ_W'({hh_s5, {(2*HALF_W){1'b0}}})
			+ SQ_W'({hl_s5, {(HALF_W+1){1'b0}}})
			+ SQ_W'(ll_s5)
			+ (SQ_W'(1) << RND_BIT);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s6.clip <= ovf_s5 | sum[SQ_W-1];
			res_s6.mz   <= (ovf_s5 | sum[SQ_W-1]) ? '1 : sum[SQ_W-2:MZ_LSB];
		end
	end

	assign res = res_s6;

endmodule

@@ src/tmc_isqrt.sv @@
// ---------------------------------------------------------------------------
// tmc_isqrt
// Pipelined floor square root of m/z * 2^32, giving sqrt(m/z) in Q8.24.
// Two root bits are settled in each stage.
// ---------------------------------------------------------------------------
module tmc_isqrt import tmc_pkg::*; (
	input  logic              clk,
	input  logic              adv,
	input  logic [MZ_W-1:0]   mz,
	output logic [ROOT_W-1:0] root
);

	sq_state_t       sq_s [SQ_STAGES];
	logic [MZ_W-1:0] xs_s [SQ_STAGES];

	// Each stage consumes the top four radicand bits; the low half of the
	// radicand is zero, so the shifted word fills with zeros.
	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
		sq_state_t       cur, mid, nxt;
		logic [MZ_W-1:0] xin;

		if (k == 0) begin : g_first
			assign cur = '0;
			assign xin = mz;
		end else begin : g_rest
			assign cur = sq_s[k-1];
			assign xin = xs_s[k-1];
		end

		assign mid = sqrt_step(cur, xin[MZ_W-1 -: 2]);
		assign nxt = sqrt_step(mid, xin[MZ_W-3 -: 2]);

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[k] <= nxt;
				xs_s[k] <= {xin[MZ_W-5:0], 4'b0000};
			end
		end
	end

	assign root = sq_s[SQ_STAGES-1].root;

endmodule

@@ src/tmc_div.sv @@
// ---------------------------------------------------------------------------
// tmc_div
// Inverse back end: tof = round((root - intercept) / slope), clamped at
// zero and saturated, by a restoring divider with one quotient bit a stage.
// ---------------------------------------------------------------------------
module tmc_div import tmc_pkg::*; #(
	parameter int TOF_WIDTH = 20
) (
	input  logic                 clk,
	input  logic                 adv,
	input  logic [ROOT_W-1:0]    root,
	input  logic [ICPT_W-1:0]    icpt,
	input  logic [SLOPE_W-1:0]   slope,
	output logic [TOF_WIDTH-1:0] tof,
	output logic                 clip
);

	localparam int CMP_W = DIV_W + TOF_WIDTH;

	logic [DIFF_W-1:0]    diff_s1;
	logic                 pos_s1;
	logic [NUM_W-1:0]     num_s2;
	logic                 pos_s2;
	logic                 ovf_s2;

	logic [DIFF_W:0]      diff;
	logic [NUM_W-1:0]     num;
	logic [DIV_W-1:0]     dvs;

	logic [NUM_W-1:0]     rem_b [TOF_WIDTH];
	logic [TOF_WIDTH-1:0] q_b   [TOF_WIDTH];
	logic                 pos_b [TOF_WIDTH];
	logic                 ovf_b [TOF_WIDTH];

	assign dvs = {slope, 1'b0};

	// Stage 1: difference between the root and the intercept.
	always_comb begin
		diff = (DIFF_W+1)'(root) - {{(DIFF_W+1-ICPT_W){icpt[ICPT_W-1]}}, icpt};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s1 <= diff[DIFF_W-1:0];
			pos_s1  <= !diff[DIFF_W] && (diff != '0);
		end
	end

	// Stage 2: numerator with the rounding half slope and the quotient range
	// check against 2^TOF_WIDTH. A zero slope saturates a positive difference.
	always_comb begin
		num = NUM_W'({diff_s1, {NUM_SHIFT{1'b0}}}) + NUM_W'(slope);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s2 <= num;
			pos_s2 <= pos_s1;
			ovf_s2 <= pos_s1 && (CMP_W'(num) >= (CMP_W'(dvs) << TOF_WIDTH));
		end
	end

	// Quotient stages, most significant bit first.
	for (genvar j = 0; j < TOF_WIDTH; j++) begin : g_bit
		localparam int BIT = TOF_WIDTH - 1 - j;

		logic [NUM_W-1:0]     rem_in;
		logic [TOF_WIDTH-1:0] q_in;
		logic [TOF_WIDTH-1:0] q_nx;
		logic                 pos_in, ovf_in;
		logic [CMP_W-1:0]     dsh;
		logic                 ge;

		if (j == 0) begin : g_first
			assign rem_in = num_s2;
			assign q_in   = '0;
			assign pos_in = pos_s2;
			assign ovf_in = ovf_s2;
		end else begin : g_rest
			assign rem_in = rem_b[j-1];
			assign q_in   = q_b[j-1];
			assign pos_in = pos_b[j-1];
			assign ovf_in = ovf_b[j-1];
		end

		assign dsh  = CMP_W'(dvs) << BIT;
		assign ge   = CMP_W'(rem_in) >= dsh;
		assign q_nx = q_in | (TOF_WIDTH'(ge) << BIT);

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_b[j]      <= ge ? NUM_W'(CMP_W'(rem_in) - dsh) : rem_in;
				q_b[j]        <= q_nx;
				pos_b[j]      <= pos_in;
				ovf_b[j]      <= ovf_in;
			end
		end
	end

	// Clamp and saturate.
	assign tof  = !pos_b[TOF_WIDTH-1] ? '0 :
		(ovf_b[TOF_WIDTH-1] ? '1 : q_b[TOF_WIDTH-1]);
	assign clip = ovf_b[TOF_WIDTH-1];

endmodule

@@ src/tof_to_mz_sqrt_calibration_top.sv @@
// ---------------------------------------------------------------------------
// tof_to_mz_sqrt_calibration_top
// Converts between a time-of-flight sample index and m/z with a calibration
// linear in sqrt(m/z), in both directions, one word per clock.
//
//   Channel   Direction  Handshake             Payload
//   cfg       in         cfg_we                cfg_index, cfg_data
//   in        in         in_valid / in_stall   mode, tof_index, mz_value
//   out       out        out_valid / out_stall mz_result, tof_result, clipped
//
// One word is accepted every cycle while the output is not held.
// The depth is set by the 16-stage square root and the one-bit-per-stage
// divider, with the forward results delayed to match.
// A held output freezes the whole pipeline and raises in_stall in that cycle.
// Reset clears the valid bits and loads intercept 0 and a slope of one
// LSB; no clearing pass is needed.
// ---------------------------------------------------------------------------
module tof_to_mz_sqrt_calibration_top import tmc_pkg::*; #(
	parameter int TOF_WIDTH = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 mode,
	input  logic [TOF_WIDTH-1:0] tof_index,
	input  logic [MZ_W-1:0]      mz_value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [MZ_W-1:0]      mz_result,
	output logic [TOF_WIDTH-1:0] tof_result,
	output logic                 clipped
);

	localparam int LAT = SQ_STAGES + DIV_PRE + TOF_WIDTH;
	localparam int FD  = LAT - FWD_STAGES;

	logic [ICPT_W-1:0]    icpt_q;
	logic [SLOPE_W-1:0]   slope_q;
	logic                 adv;

	logic                 vld_s  [LAT];
	logic                 mode_s [LAT];
	fwd_res_t             fd_s   [FD];

	fwd_res_t             fwd_res;
	logic [ROOT_W-1:0]    root;
	logic [TOF_WIDTH-1:0] div_tof;
	logic                 div_clip;

	logic                 out_valid_q;
	logic [MZ_W-1:0]      mz_q;
	logic [TOF_WIDTH-1:0] tof_q;
	logic                 clip_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icpt_q  <= '0;
			slope_q <= SLOPE_W'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_INTERCEPT: icpt_q  <= cfg_data[ICPT_W-1:0];
				REG_SLOPE:     slope_q <= cfg_data[SLOPE_W-1:0];
				default:       ;
			endcase
		end
	end

	// The pipeline moves whenever the output register can take a word.
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// Mode and forward results are delayed to line up with the inverse path.
	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s[0] <= mode;
			for (int i = 1; i < LAT; i++) begin
				mode_s[i] <= mode_s[i-1];
			end
			fd_s[0] <= fwd_res;
			for (int i = 1; i < FD; i++) begin
				fd_s[i] <= fd_s[i-1];
			end
		end
	end

	tmc_fwd #(
		.TOF_WIDTH(TOF_WIDTH)
	) u_fwd (
		.clk   (clk),
		.adv   (adv),
		.slope (slope_q),
		.icpt  (icpt_q),
		.tof   (tof_index),
		.res   (fwd_res)
	);

	tmc_isqrt u_isqrt (
		.clk  (clk),
		.adv  (adv),
		.mz   (mz_value),
		.root (root)
	);

	tmc_div #(
		.TOF_WIDTH(TOF_WIDTH)
	) u_div (
		.clk   (clk),
		.adv   (adv),
		.root  (root),
		.icpt  (icpt_q),
		.slope (slope_q),
		.tof   (div_tof),
		.clip  (div_clip)
	);

	// Output register: select the direction and clear the unused field.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mz_q   <= mode_s[LAT-1] ? '0 : fd_s[FD-1].mz;
			tof_q  <= mode_s[LAT-1] ? div_tof : '0;
			clip_q <= mode_s[LAT-1] ? div_clip : fd_s[FD-1].clip;
		end
	end

	assign out_valid  = out_valid_q;
	assign mz_result  = mz_q;
	assign tof_result = tof_q;
	assign clipped    = clip_q;

endmodule

@@ src/tmc_checker.sv @@
// ---------------------------------------------------------------------------
// tmc_checker
// Port-level checks of the calibration block, bound to the top level.
// ---------------------------------------------------------------------------
`include "tof_to_mz_sqrt_calibration_top_macros.svh"

module tmc_checker #(
	parameter int TOF_WIDTH = 20
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_we,
	input logic [0:0]           cfg_index,
	input logic [47:0]          cfg_data,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 mode,
	input logic [TOF_WIDTH-1:0] tof_index,
	input logic [31:0]          mz_value,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [31:0]          mz_result,
	input logic [TOF_WIDTH-1:0] tof_result,
	input logic                 clipped
);

	// A held word stays on the output.
	`TMC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "output word dropped while held")

	// The input is only held back by a held output word.
	`TMC_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without cause")

	// Only one direction carries a nonzero result.
	`TMC_ASSERT_IMPL(a_one_field, out_valid && (tof_result != '0), mz_result == '0, "both result fields set")

	// A clipped word sits at the maximum of its field.
	`TMC_ASSERT_IMPL(a_clip_max, out_valid && clipped, (mz_result == '1) || (tof_result == '1), "clipped word not saturated")

endmodule

bind tof_to_mz_sqrt_calibration_top tmc_checker #(
	.TOF_WIDTH(TOF_WIDTH)
) u_tmc_checker (.*);
